[design/sglt_pkg.sv]
`timescale 1ns / 1ps

package sglt_pkg;

   // Table geometry and field widths.
   localparam int TABLE_DEPTH  = 16;
   localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS     = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_BITS    = 48;
   localparam int LEN_BITS     = 32;
   localparam int AMOUNT_BITS  = 40;
   localparam int TOTAL_BITS   = 36;
   localparam int CMD_BITS     = 2;
   localparam int STATUS_BITS  = 2;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_FILL_BITS = $clog2(QUEUE_DEPTH + 1);

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [CMD_BITS-1:0] {
      OP_APPEND = 2'd0,
      OP_REMOVE = 2'd1,
      OP_KEEP   = 2'd2,
      OP_READ   = 2'd3
   } sglt_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_COPY,
      ST_LOAD0,
      ST_DONE
   } sglt_state_type;

   // One classified command as it travels through the queue.
   typedef struct packed {
      sglt_op_type             op;
      logic                    amount_zero;
      logic [AMOUNT_BITS-1:0]  amount;
      logic [ADDR_BITS-1:0]    desc_address;
      logic [LEN_BITS-1:0]     desc_length;
      logic [IDX_BITS-1:0]     entry_index;
   } sglt_item_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic           valid;
      sglt_item_type  item;
   } sglt_head_type;

endpackage

[design/scatter_gather_list_trim_core.sv]
`timescale 1ns / 1ps

// Scatter-gather descriptor table with append, read, remove-prefix and
// keep-prefix commands. A command word is taken when start is high and busy
// is low; busy rises only when the two-deep command queue is full, so a
// host may issue a second command while the first is still being worked.
// Every command produces exactly one response word, shown for one cycle
// with rsp_strobe high; the receiver cannot stall, so it must sample the
// response in that cycle. Once a command leaves the queue, append writes the
// table in the exec state if it has room and reloads entry 0 before the
// response, and read issues its table read in the exec state before the
// response. Remove-prefix and keep-prefix walk the table one entry per cycle
// through the single table read port, and remove-prefix then moves the
// surviving entries behind the cut to the front, one per cycle.

module scatter_gather_list_trim_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [sglt_pkg::CMD_BITS-1:0]     req_cmd,
   input  logic [sglt_pkg::AMOUNT_BITS-1:0]  req_amount,
   input  logic [sglt_pkg::ADDR_BITS-1:0]    req_desc_address,
   input  logic [sglt_pkg::LEN_BITS-1:0]     req_desc_length,
   input  logic [sglt_pkg::IDX_BITS-1:0]     req_entry_index,
   output logic                              rsp_strobe,
   output logic [sglt_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [sglt_pkg::CNT_BITS-1:0]     rsp_entry_count,
   output logic [sglt_pkg::TOTAL_BITS-1:0]   rsp_byte_total,
   output logic [sglt_pkg::ADDR_BITS-1:0]    rsp_entry_address,
   output logic [sglt_pkg::LEN_BITS-1:0]     rsp_entry_length
);

   // The front decodes and queues command words; the back owns the table.
   sglt_pkg::sglt_head_type  head;
   logic                     pop;

   sglt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_amount       (req_amount),
      .req_desc_address (req_desc_address),
      .req_desc_length  (req_desc_length),
      .req_entry_index  (req_entry_index),
      .head             (head),
      .pop              (pop)
   );

   sglt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_byte_total    (rsp_byte_total),
      .rsp_entry_address (rsp_entry_address),
      .rsp_entry_length  (rsp_entry_length)
   );

   // The table never reports more entries than it can hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_entry_count <= sglt_pkg::CNT_BITS'(sglt_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // A refused append is only possible on a full table.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == sglt_pkg::STATUS_FULL) |->
         rsp_entry_count == sglt_pkg::CNT_BITS'(sglt_pkg::TABLE_DEPTH))
      else $error("append refused on a table with room");

   // An empty table holds no bytes and reports no entry.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_entry_count == '0 && rsp_status != sglt_pkg::STATUS_FULL) |->
         (rsp_byte_total == '0 && rsp_entry_address == '0 && rsp_entry_length == '0))
      else $error("empty table reports bytes or an entry");

   // Each response lasts a single cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

endmodule

[design/sglt_front.sv]
`timescale 1ns / 1ps

module sglt_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [sglt_pkg::CMD_BITS-1:0]     req_cmd,
   input  logic [sglt_pkg::AMOUNT_BITS-1:0]  req_amount,
   input  logic [sglt_pkg::ADDR_BITS-1:0]    req_desc_address,
   input  logic [sglt_pkg::LEN_BITS-1:0]     req_desc_length,
   input  logic [sglt_pkg::IDX_BITS-1:0]     req_entry_index,
   output sglt_pkg::sglt_head_type           head,
   input  logic                              pop
);

   sglt_pkg::sglt_item_type                     queue_ff [sglt_pkg::QUEUE_DEPTH];
   logic [sglt_pkg::QUEUE_PTR_BITS-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [sglt_pkg::QUEUE_PTR_BITS-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [sglt_pkg::QUEUE_FILL_BITS-1:0]        fill_ff, fill_in;
   sglt_pkg::sglt_item_type                     item;
   logic                                        push;
   logic                                        do_pop;

   // Decode the command word and flag a zero byte count up front.
   always_comb begin
      item.op           = sglt_pkg::sglt_op_type'(req_cmd);
      item.amount_zero  = (req_amount == '0);
      item.amount       = req_amount;
      item.desc_address = req_desc_address;
      item.desc_length  = req_desc_length;
      item.entry_index  = req_entry_index;
   end

   assign busy   = (fill_ff == sglt_pkg::QUEUE_FILL_BITS'(sglt_pkg::QUEUE_DEPTH));
   assign push   = start && !busy;
   assign do_pop = pop && (fill_ff != '0);

   assign head.valid = (fill_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + sglt_pkg::QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + sglt_pkg::QUEUE_PTR_BITS'(1);
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + sglt_pkg::QUEUE_FILL_BITS'(1);
      end else if (!push && do_pop) begin
         fill_in = fill_ff - sglt_pkg::QUEUE_FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

[design/sglt_back.sv]
`timescale 1ns / 1ps

module sglt_back (
   input  logic                              clock,
   input  logic                              reset,
   input  sglt_pkg::sglt_head_type           head,
   output logic                              pop,
   output logic                              rsp_strobe,
   output logic [sglt_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [sglt_pkg::CNT_BITS-1:0]     rsp_entry_count,
   output logic [sglt_pkg::TOTAL_BITS-1:0]   rsp_byte_total,
   output logic [sglt_pkg::ADDR_BITS-1:0]    rsp_entry_address,
   output logic [sglt_pkg::LEN_BITS-1:0]     rsp_entry_length
);

   // Descriptor table: one write port, one registered read port.
   logic [sglt_pkg::ADDR_BITS-1:0]    mem_addr_ff [sglt_pkg::TABLE_DEPTH];
   logic [sglt_pkg::LEN_BITS-1:0]     mem_len_ff  [sglt_pkg::TABLE_DEPTH];
   logic [sglt_pkg::ADDR_BITS-1:0]    rd_addr_ff;
   logic [sglt_pkg::LEN_BITS-1:0]     rd_len_ff;
   logic                              wr_en;
   logic [sglt_pkg::IDX_BITS-1:0]     wr_idx;
   logic [sglt_pkg::ADDR_BITS-1:0]    wr_addr;
   logic [sglt_pkg::LEN_BITS-1:0]     wr_len;
   logic [sglt_pkg::IDX_BITS-1:0]     rd_idx;

   sglt_pkg::sglt_state_type          state_ff, state_in;
   sglt_pkg::sglt_op_type             op_ff, op_in;
   logic                              zero_ff, zero_in;
   logic [sglt_pkg::AMOUNT_BITS-1:0]  amount_ff, amount_in;
   logic [sglt_pkg::ADDR_BITS-1:0]    app_addr_ff, app_addr_in;
   logic [sglt_pkg::LEN_BITS-1:0]     app_len_ff, app_len_in;
   logic [sglt_pkg::IDX_BITS-1:0]     index_ff, index_in;
   logic [sglt_pkg::CNT_BITS-1:0]     count_ff, count_in;
   logic [sglt_pkg::TOTAL_BITS-1:0]   bytes_ff, bytes_in;
   logic [sglt_pkg::CNT_BITS-1:0]     src_ff, src_in;
   logic [sglt_pkg::CNT_BITS-1:0]     dst_ff, dst_in;
   logic [sglt_pkg::STATUS_BITS-1:0]  status_ff, status_in;
   logic                              have_ff, have_in;

   logic [sglt_pkg::AMOUNT_BITS-1:0]  len_ext;
   logic [sglt_pkg::CNT_BITS-1:0]     src_next;
   logic                              n_ge_total;
   logic                              n_lt_len;
   logic                              n_eq_len;
   logic                              table_full;
   logic                              index_ok;
   logic                              src_end;

   assign len_ext    = sglt_pkg::AMOUNT_BITS'(rd_len_ff);
   assign src_next   = src_ff + sglt_pkg::CNT_BITS'(1);
   assign n_ge_total = (amount_ff >= sglt_pkg::AMOUNT_BITS'(bytes_ff));
   assign n_lt_len   = (amount_ff < len_ext);
   assign n_eq_len   = (amount_ff == len_ext);
   assign table_full = (count_ff >= sglt_pkg::CNT_BITS'(sglt_pkg::TABLE_DEPTH));
   assign index_ok   = (sglt_pkg::CNT_BITS'(index_ff) < count_ff);
   assign src_end    = (src_ff >= count_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sglt_pkg::ST_IDLE: begin
            if (head.valid) begin
               state_in = sglt_pkg::ST_EXEC;
            end
         end
         sglt_pkg::ST_EXEC: begin
            case (op_ff)
               sglt_pkg::OP_APPEND: state_in = sglt_pkg::ST_LOAD0;
               sglt_pkg::OP_READ:   state_in = sglt_pkg::ST_DONE;
               sglt_pkg::OP_REMOVE, sglt_pkg::OP_KEEP: begin
                  if (n_ge_total || zero_ff) begin
                     state_in = sglt_pkg::ST_DONE;
                  end else begin
                     state_in = sglt_pkg::ST_WALK;
                  end
               end
               default: state_in = sglt_pkg::ST_DONE;
            endcase
         end
         sglt_pkg::ST_WALK: begin
            if (src_end) begin
               state_in = sglt_pkg::ST_LOAD0;
            end else if (op_ff == sglt_pkg::OP_REMOVE) begin
               if (n_lt_len) begin
                  state_in = (src_ff == '0) ? sglt_pkg::ST_LOAD0 : sglt_pkg::ST_COPY;
               end else if (n_eq_len) begin
                  state_in = sglt_pkg::ST_COPY;
               end
            end else if (n_lt_len || n_eq_len) begin
               state_in = sglt_pkg::ST_LOAD0;
            end
         end
         sglt_pkg::ST_COPY: begin
            if (src_end) begin
               state_in = sglt_pkg::ST_DONE;
            end
         end
         sglt_pkg::ST_LOAD0: state_in = sglt_pkg::ST_DONE;
         sglt_pkg::ST_DONE:  state_in = sglt_pkg::ST_IDLE;
         default:            state_in = sglt_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      op_in       = op_ff;
      zero_in     = zero_ff;
      amount_in   = amount_ff;
      app_addr_in = app_addr_ff;
      app_len_in  = app_len_ff;
      index_in    = index_ff;
      count_in    = count_ff;
      bytes_in    = bytes_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      status_in   = status_ff;
      have_in     = have_ff;
      pop         = 1'b0;
      rsp_strobe  = 1'b0;
      wr_en       = 1'b0;
      wr_idx      = '0;
      wr_addr     = rd_addr_ff;
      wr_len      = rd_len_ff;
      rd_idx      = '0;
      case (state_ff)
         sglt_pkg::ST_IDLE: begin
            pop         = head.valid;
            op_in       = head.item.op;
            zero_in     = head.item.amount_zero;
            amount_in   = head.item.amount;
            app_addr_in = head.item.desc_address;
            app_len_in  = head.item.desc_length;
            index_in    = head.item.entry_index;
            src_in      = '0;
            dst_in      = '0;
            status_in   = sglt_pkg::STATUS_OK;
            have_in     = 1'b0;
         end
         sglt_pkg::ST_EXEC: begin
            case (op_ff)
               sglt_pkg::OP_APPEND: begin
                  if (table_full) begin
                     status_in = sglt_pkg::STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_idx   = count_ff[sglt_pkg::IDX_BITS-1:0];
                     wr_addr  = app_addr_ff;
                     wr_len   = app_len_ff;
                     count_in = count_ff + sglt_pkg::CNT_BITS'(1);
                     bytes_in = bytes_ff + sglt_pkg::TOTAL_BITS'(app_len_ff);
                  end
               end
               sglt_pkg::OP_READ: begin
                  if (index_ok) begin
                     rd_idx  = index_ff;
                     have_in = 1'b1;
                  end else begin
                     status_in = sglt_pkg::STATUS_RANGE;
                  end
               end
               sglt_pkg::OP_REMOVE: begin
                  if (n_ge_total) begin
                     count_in = '0;
                     bytes_in = '0;
                  end
               end
               sglt_pkg::OP_KEEP: begin
                  if (!n_ge_total) begin
                     if (zero_ff) begin
                        count_in = '0;
                        bytes_in = '0;
                     end else begin
                        // The kept total is simply n; set it before the walk.
                        bytes_in = amount_ff[sglt_pkg::TOTAL_BITS-1:0];
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         sglt_pkg::ST_WALK: begin
            // The read for the following entry is issued speculatively.
            rd_idx = src_next[sglt_pkg::IDX_BITS-1:0];
            if (!src_end) begin
               if (op_ff == sglt_pkg::OP_REMOVE) begin
                  src_in = src_next;
                  if (n_lt_len) begin
                     // Partly consumed entry lands at the front.
                     wr_en    = 1'b1;
                     wr_idx   = '0;
                     wr_addr  = rd_addr_ff + sglt_pkg::ADDR_BITS'(amount_ff);
                     wr_len   = rd_len_ff - amount_ff[sglt_pkg::LEN_BITS-1:0];
                     bytes_in = bytes_ff - amount_ff[sglt_pkg::TOTAL_BITS-1:0];
                     dst_in   = sglt_pkg::CNT_BITS'(1);
                  end else begin
                     amount_in = amount_ff - len_ext;
                     bytes_in  = bytes_ff - sglt_pkg::TOTAL_BITS'(rd_len_ff);
                     dst_in    = '0;
                  end
               end else begin
                  if (n_lt_len) begin
                     wr_en    = 1'b1;
                     wr_idx   = src_ff[sglt_pkg::IDX_BITS-1:0];
                     wr_len   = amount_ff[sglt_pkg::LEN_BITS-1:0];
                     count_in = src_next;
                  end else if (n_eq_len) begin
                     count_in = src_next;
                  end else begin
                     amount_in = amount_ff - len_ext;
                     src_in    = src_next;
                  end
               end
            end
         end
         sglt_pkg::ST_COPY: begin
            if (src_end) begin
               count_in = dst_ff;
               rd_idx   = '0;
            end else begin
               rd_idx = src_next[sglt_pkg::IDX_BITS-1:0];
               wr_en  = 1'b1;
               wr_idx = dst_ff[sglt_pkg::IDX_BITS-1:0];
               src_in = src_next;
               dst_in = dst_ff + sglt_pkg::CNT_BITS'(1);
            end
         end
         sglt_pkg::ST_LOAD0: begin
            rd_idx = '0;
         end
         sglt_pkg::ST_DONE: begin
            rsp_strobe = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_status        = status_ff;
   assign rsp_entry_count   = count_ff;
   assign rsp_byte_total    = bytes_ff;
   assign rsp_entry_address = (have_ff || count_ff != '0) ? rd_addr_ff : '0;
   assign rsp_entry_length  = (have_ff || count_ff != '0) ? rd_len_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sglt_pkg::ST_IDLE;
         count_ff <= '0;
         bytes_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bytes_ff <= bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      zero_ff     <= zero_in;
      amount_ff   <= amount_in;
      app_addr_ff <= app_addr_in;
      app_len_ff  <= app_len_in;
      index_ff    <= index_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      status_ff   <= status_in;
      have_ff     <= have_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_addr_ff[wr_idx] <= wr_addr;
         mem_len_ff[wr_idx]  <= wr_len;
      end
      rd_addr_ff <= mem_addr_ff[rd_idx];
      rd_len_ff  <= mem_len_ff[rd_idx];
   end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the scatter-gather descriptor table. Command words are
// driven on the falling edge and taken at the rising edge where start is high
// and busy is low. At that edge a shadow copy of the table is updated and the
// response word it implies is queued. Every strobed response is compared,
// field by field, with the oldest queued word. The receiver cannot stall, so
// only the sender idles. It draws a random gap before each word, and some
// runs of random traffic go with no gaps at all.

module testbench;

   // No accepted command word and no response word for this many cycles means
   // the block is hung.
   localparam int WATCHDOG_LIMIT = 1000;
   // Quiet time after the last response. It must cover the longest trim, so
   // that a stray strobe would still be seen.
   localparam int SETTLE_CYCLES  = 80;
   localparam int RANDOM_WORDS   = 530;

   // One command word as the bench drives it.
   typedef struct packed {
      sglt_pkg::sglt_op_type             cmd;
      logic [sglt_pkg::AMOUNT_BITS-1:0]  amount;
      logic [sglt_pkg::ADDR_BITS-1:0]    address;
      logic [sglt_pkg::LEN_BITS-1:0]     length;
      logic [sglt_pkg::IDX_BITS-1:0]     index;
   } command_word_type;

   // One response word as the block should show it.
   typedef struct packed {
      logic [sglt_pkg::STATUS_BITS-1:0]  status;
      logic [sglt_pkg::CNT_BITS-1:0]     count;
      logic [sglt_pkg::TOTAL_BITS-1:0]   total;
      logic [sglt_pkg::ADDR_BITS-1:0]    address;
      logic [sglt_pkg::LEN_BITS-1:0]     length;
   } response_word_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              start = 1'b0;
   logic [sglt_pkg::CMD_BITS-1:0]     req_cmd = '0;
   logic [sglt_pkg::AMOUNT_BITS-1:0]  req_amount = '0;
   logic [sglt_pkg::ADDR_BITS-1:0]    req_desc_address = '0;
   logic [sglt_pkg::LEN_BITS-1:0]     req_desc_length = '0;
   logic [sglt_pkg::IDX_BITS-1:0]     req_entry_index = '0;
   logic                              busy;
   logic                              rsp_strobe;
   logic [sglt_pkg::STATUS_BITS-1:0]  rsp_status;
   logic [sglt_pkg::CNT_BITS-1:0]     rsp_entry_count;
   logic [sglt_pkg::TOTAL_BITS-1:0]   rsp_byte_total;
   logic [sglt_pkg::ADDR_BITS-1:0]    rsp_entry_address;
   logic [sglt_pkg::LEN_BITS-1:0]     rsp_entry_length;

   // Shadow copy of the descriptor table. Only positions below the count are
   // ever read, so the entries need no reset.
   logic [sglt_pkg::ADDR_BITS-1:0]    shadow_address [sglt_pkg::TABLE_DEPTH];
   logic [sglt_pkg::LEN_BITS-1:0]     shadow_length [sglt_pkg::TABLE_DEPTH];
   int unsigned                       shadow_count = 0;
   logic [sglt_pkg::TOTAL_BITS-1:0]   shadow_bytes = '0;

   // Responses still owed by the block, oldest first.
   response_word_type                 responses_due [$];

   int                                failures = 0;
   int                                words_checked = 0;
   int                                op_tally [4] = '{0, 0, 0, 0};
   int                                full_refusals = 0;
   int                                range_misses = 0;
   int                                idle_cycles = 0;
   bit                                burst_gaps = 1'b0;

   always #2 clock = ~clock;

   scatter_gather_list_trim_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_amount        (req_amount),
      .req_desc_address  (req_desc_address),
      .req_desc_length   (req_desc_length),
      .req_entry_index   (req_entry_index),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_byte_total    (rsp_byte_total),
      .rsp_entry_address (rsp_entry_address),
      .rsp_entry_length  (rsp_entry_length)
   );

   // Applies one command to the shadow table and returns the response word it
   // implies. A remove walks from the front: each entry that the count covers
   // completely is dropped, zero-length ones included, and the first entry it
   // only partly covers has its address advanced and its length cut. A keep
   // walks until the kept bytes run out and drops everything after that point.
   function automatic response_word_type apply_command(command_word_type w);
      response_word_type                 r;
      logic [sglt_pkg::AMOUNT_BITS-1:0]  left;
      logic [sglt_pkg::LEN_BITS-1:0]     len;
      int unsigned                       walked;
      int unsigned                       k;
      bit                                have_entry;
      r = '0;
      r.status = sglt_pkg::STATUS_OK;
      have_entry = 1'b0;
      case (w.cmd)
         sglt_pkg::OP_APPEND: begin
            if (shadow_count >= sglt_pkg::TABLE_DEPTH) begin
               r.status = sglt_pkg::STATUS_FULL;
               full_refusals++;
            end else begin
               shadow_address[shadow_count] = w.address;
               shadow_length[shadow_count] = w.length;
               shadow_count++;
               shadow_bytes = shadow_bytes + w.length;
            end
         end
         sglt_pkg::OP_REMOVE: begin
            if (w.amount >= shadow_bytes) begin
               shadow_count = 0;
               shadow_bytes = '0;
            end else begin
               left = w.amount;
               walked = 0;
               while (walked < shadow_count && left != 0) begin
                  len = shadow_length[walked];
                  if (left < len) begin
                     // The address wraps at the address width.
                     shadow_address[walked] = shadow_address[walked] + left;
                     shadow_length[walked] = len - left[sglt_pkg::LEN_BITS-1:0];
                     shadow_bytes = shadow_bytes - left;
                     break;
                  end
                  left = left - len;
                  shadow_bytes = shadow_bytes - len;
                  walked++;
               end
               if (walked > 0) begin
                  for (k = walked; k < shadow_count; k++) begin
                     shadow_address[k - walked] = shadow_address[k];
                     shadow_length[k - walked] = shadow_length[k];
                  end
                  shadow_count = shadow_count - walked;
               end
            end
         end
         sglt_pkg::OP_KEEP: begin
            // A keep at or beyond the total leaves the table alone.
            if (w.amount < shadow_bytes) begin
               if (w.amount == 0) begin
                  shadow_count = 0;
                  shadow_bytes = '0;
               end else begin
                  left = w.amount;
                  walked = 0;
                  while (walked < shadow_count && left != 0) begin
                     len = shadow_length[walked];
                     walked++;
                     if (left < len) begin
                        shadow_length[walked - 1] = left[sglt_pkg::LEN_BITS-1:0];
                        break;
                     end
                     left = left - len;
                  end
                  shadow_count = walked;
                  shadow_bytes = w.amount[sglt_pkg::TOTAL_BITS-1:0];
               end
            end
         end
         sglt_pkg::OP_READ: begin
            if (w.index < shadow_count) begin
               r.address = shadow_address[w.index];
               r.length = shadow_length[w.index];
               have_entry = 1'b1;
            end else begin
               r.status = sglt_pkg::STATUS_RANGE;
               range_misses++;
            end
         end
         default: begin
         end
      endcase
      // Outside a successful read, the response shows entry 0, or zeros for an
      // empty table.
      if (!have_entry && shadow_count > 0) begin
         r.address = shadow_address[0];
         r.length = shadow_length[0];
      end
      r.count = shadow_count[sglt_pkg::CNT_BITS-1:0];
      r.total = shadow_bytes;
      return r;
   endfunction

   function automatic command_word_type make_word(
         sglt_pkg::sglt_op_type cmd,
         logic [sglt_pkg::AMOUNT_BITS-1:0] amount,
         logic [sglt_pkg::ADDR_BITS-1:0] address,
         logic [sglt_pkg::LEN_BITS-1:0] length,
         logic [sglt_pkg::IDX_BITS-1:0] index);
      command_word_type w;
      w.cmd = cmd;
      w.amount = amount;
      w.address = address;
      w.length = length;
      w.index = index;
      return w;
   endfunction

   function automatic int unsigned next_gap();
      return burst_gaps ? 0 : $urandom_range(0, 12);
   endfunction

   // Drives one word after a gap and waits until the block takes it. The
   // shadow table moves forward at the same edge where the block takes the
   // word. Start is lowered only when a gap follows, so a back-to-back word
   // keeps start high without a glitch.
   task automatic send_word(command_word_type w, int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_cmd <= w.cmd;
      req_amount <= w.amount;
      req_desc_address <= w.address;
      req_desc_length <= w.length;
      req_entry_index <= w.index;
      @(posedge clock);
      while (busy) @(posedge clock);
      responses_due.push_back(apply_command(w));
      op_tally[w.cmd]++;
   endtask

   // Stops sending and waits until the block has answered every word it has
   // taken.
   task automatic wait_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (responses_due.size() != 0) @(posedge clock);
   endtask

   // Commands on an empty table: reads are out of range, and removes and keeps
   // leave the table empty.
   task automatic test_empty_table();
      send_word(make_word(sglt_pkg::OP_READ, '0, '0, '0, 4'd0), next_gap());
      send_word(make_word(sglt_pkg::OP_READ, '0, '0, '0, 4'd15), next_gap());
      send_word(make_word(sglt_pkg::OP_REMOVE, '0, '0, '0, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_KEEP, '1, '0, '0, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_KEEP, '0, '0, '0, '0), next_gap());
   endtask

   // Appends with extreme and alternating bit patterns, then reads inside and
   // past the count.
   task automatic test_append_and_read();
      send_word(make_word(sglt_pkg::OP_APPEND, '0, '1, '1, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_APPEND, '0, '0, '0, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_APPEND, '0, 48'h5555_5555_5555, 32'hAAAA_AAAA,
                          '0), next_gap());
      send_word(make_word(sglt_pkg::OP_APPEND, '0, 48'hAAAA_AAAA_AAAA, 32'h5555_5555,
                          '0), next_gap());
      send_word(make_word(sglt_pkg::OP_READ, '0, '0, '0, 4'd0), next_gap());
      send_word(make_word(sglt_pkg::OP_READ, '0, '0, '0, 4'd3), next_gap());
      send_word(make_word(sglt_pkg::OP_READ, '0, '0, '0, 4'd4), next_gap());
      send_word(make_word(sglt_pkg::OP_READ, '0, '0, '0, 4'd15), next_gap());
   endtask

   // Removes a single byte, so that the all-ones address wraps to zero. Then an
   // exact consume of the first entry leaves a zero-length entry at the front,
   // the next remove walks over it, and a remove of the largest count empties
   // the table.
   task automatic test_remove_prefix();
      send_word(make_word(sglt_pkg::OP_REMOVE, 40'd1, '0, '0, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_REMOVE, 40'hFFFF_FFFE, '0, '0, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_REMOVE, 40'd1, '0, '0, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_REMOVE, '1, '0, '0, '0), next_gap());
   endtask

   // Builds a table with zero-length entries between real ones. A keep beyond
   // the total changes nothing. A keep that ends on an entry boundary drops the
   // zero-length entries after it. A keep inside an entry cuts that entry, and
   // a keep of zero empties the table.
   task automatic test_keep_prefix();
      send_word(make_word(sglt_pkg::OP_APPEND, '0, 48'h1000, 32'd16, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_APPEND, '0, 48'h2000, 32'd0, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_APPEND, '0, 48'h3000, 32'd8, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_APPEND, '0, 48'h4000, 32'd0, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_KEEP, 40'd30, '0, '0, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_KEEP, 40'd16, '0, '0, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_KEEP, 40'd10, '0, '0, '0), next_gap());
      send_word(make_word(sglt_pkg::OP_KEEP, '0, '0, '0, '0), next_gap());
   endtask

   function automatic logic [sglt_pkg::LEN_BITS-1:0] random_length();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return $urandom_range(1, 16);
         2: return $urandom_range(1, 4096);
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [sglt_pkg::ADDR_BITS-1:0] random_address();
      case ($urandom_range(0, 3))
         0: return 48'hFFFF_FFFF_FFFF - $urandom_range(0, 64);
         1: return $urandom_range(0, 255);
         default: return sglt_pkg::ADDR_BITS'({$urandom, $urandom});
      endcase
   endfunction

   // Trim counts that land on the interesting points of the current table:
   // zero, the total and just past or below it, the entry boundaries and their
   // neighbors, any count up to the total, and any count at all.
   function automatic logic [sglt_pkg::AMOUNT_BITS-1:0] trim_amount();
      logic [sglt_pkg::AMOUNT_BITS-1:0] boundary;
      logic [sglt_pkg::AMOUNT_BITS-1:0] span;
      int unsigned                      upto;
      int unsigned                      k;
      boundary = '0;
      upto = $urandom_range(0, shadow_count);
      for (k = 0; k < upto; k++) boundary = boundary + shadow_length[k];
      span = shadow_bytes + 1;
      case ($urandom_range(0, 8))
         0: return '0;
         1: return shadow_bytes;
         2: return shadow_bytes + $urandom_range(1, 3);
         3: return shadow_bytes - 1;
         4: return boundary;
         5: return boundary + 1;
         6: return boundary - 1;
         7: return sglt_pkg::AMOUNT_BITS'({$urandom, $urandom}) % span;
         default: return sglt_pkg::AMOUNT_BITS'({$urandom, $urandom});
      endcase
   endfunction

   // Every field is randomized for every command, so the unused ones still
   // toggle. The grow bias sets how many of the words are appends, which
   // controls how often the table fills up and refuses appends.
   function automatic command_word_type random_word(int unsigned grow_bias);
      command_word_type w;
      int unsigned      pick;
      w.cmd = sglt_pkg::OP_READ;
      w.amount = sglt_pkg::AMOUNT_BITS'({$urandom, $urandom});
      w.address = random_address();
      w.length = random_length();
      w.index = sglt_pkg::IDX_BITS'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < grow_bias) begin
         w.cmd = sglt_pkg::OP_APPEND;
      end else begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            w.cmd = sglt_pkg::OP_REMOVE;
         end else if (pick < 7) begin
            w.cmd = sglt_pkg::OP_KEEP;
         end
      end
      if (w.cmd == sglt_pkg::OP_REMOVE || w.cmd == sglt_pkg::OP_KEEP) begin
         w.amount = trim_amount();
      end
      if (w.cmd == sglt_pkg::OP_READ && shadow_count > 0 &&
          $urandom_range(0, 1) == 1) begin
         w.index = sglt_pkg::IDX_BITS'($urandom_range(0, shadow_count - 1));
      end
      return w;
   endfunction

   // Random traffic in runs. Each run has its own append bias, and some runs
   // send with no gaps. After some of the runs the sender stops until every
   // response has come back.
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned run_left;
      int unsigned grow_bias;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         run_left = $urandom_range(8, 30);
         grow_bias = $urandom_range(20, 80);
         burst_gaps = ($urandom_range(0, 3) == 0);
         repeat (run_left) begin
            send_word(random_word(grow_bias), next_gap());
            sent++;
         end
         if ($urandom_range(0, 2) == 0) begin
            wait_until_drained();
         end
      end
      burst_gaps = 1'b0;
   endtask

   // Each strobed response must match the oldest word still owed.
   always @(posedge clock) begin : check_responses
      response_word_type due;
      if (!reset && rsp_strobe) begin
         if (responses_due.size() == 0) begin
            $error("Response word with no command outstanding");
            failures++;
         end else begin
            due = responses_due.pop_front();
            words_checked++;
            if (rsp_status !== due.status) begin
               $error("rsp_status expected %0d actual %0d", due.status, rsp_status);
               failures++;
            end
            if (rsp_entry_count !== due.count) begin
               $error("rsp_entry_count expected %0d actual %0d", due.count,
                      rsp_entry_count);
               failures++;
            end
            if (rsp_byte_total !== due.total) begin
               $error("rsp_byte_total expected %0h actual %0h", due.total,
                      rsp_byte_total);
               failures++;
            end
            if (rsp_entry_address !== due.address) begin
               $error("rsp_entry_address expected %0h actual %0h", due.address,
                      rsp_entry_address);
               failures++;
            end
            if (rsp_entry_length !== due.length) begin
               $error("rsp_entry_length expected %0h actual %0h", due.length,
                      rsp_entry_length);
               failures++;
            end
         end
      end
   end

   // A cycle counts as progress when a command word is taken or a response is
   // strobed.
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles, %0d responses owed",
                     WATCHDOG_LIMIT, responses_due.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_append_and_read();
      test_remove_prefix();
      test_keep_prefix();
      wait_until_drained();
      test_random_traffic();
      wait_until_drained();

      // Let the block run quiet for a while, so that any stray strobe after
      // the last response is caught.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (responses_due.size() != 0) begin
         $error("%0d response words never arrived", responses_due.size());
         failures++;
      end

      $display("Checked %0d responses: %0d appends, %0d removes, %0d keeps, %0d reads.",
               words_checked, op_tally[sglt_pkg::OP_APPEND],
               op_tally[sglt_pkg::OP_REMOVE], op_tally[sglt_pkg::OP_KEEP],
               op_tally[sglt_pkg::OP_READ]);
      $display("Appends refused on a full table: %0d, reads out of range: %0d.",
               full_refusals, range_misses);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
